// File: sv/tbu_pkg.sv
// Package for the triangle barycentric unit: widths, types, constants and
// small arithmetic helpers. No dependencies.
package tbu_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 24;

  // Derived widths
  localparam int DW  = COORD_BITS + 1;          // coordinate difference
  localparam int PW  = 2 * DW;                  // product of two differences
  localparam int EW  = PW + 1;                  // edge function / determinant
  localparam int NW  = EW + FRAC_BITS + 2;      // rounding numerator
  localparam int DDW = EW + 1;                  // divisor, twice the determinant
  localparam int QB  = OUT_BITS - 1;            // quotient bits below overflow
  localparam int CW  = ((NW > DDW + QB) ? NW : DDW + QB) + 1;  // compare width

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [EW-1:0]         edge_t;
  typedef logic signed [NW-1:0]         num_t;
  typedef logic        [NW-1:0]         mag_t;
  typedef logic        [DDW-1:0]        dvs_t;
  typedef logic        [CW-1:0]         rem_t;
  typedef logic        [QB-1:0]         quo_t;
  typedef logic signed [OUT_BITS-1:0]   wgt_t;

  // Control passed to each divider lane
  typedef struct packed {
    logic en;
  } div_ctl_t;

  localparam wgt_t WGT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam wgt_t WGT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam longint DEG_ALPHA_I = (FRAC_BITS >= OUT_BITS - 1) ?
                                   -(longint'(1) <<< (OUT_BITS - 1)) :
                                   -(longint'(1) <<< FRAC_BITS);
  localparam wgt_t DEG_ALPHA = wgt_t'(DEG_ALPHA_I);

  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t mul_ext(input diff_t a, input diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

// File: sv/tbu_if.sv
// Channel interfaces of the triangle barycentric unit.
// Depends on tbu_pkg.
interface tbu_in_if;
  logic            valid;
  logic            ready;
  tbu_pkg::coord_t ax;
  tbu_pkg::coord_t ay;
  tbu_pkg::coord_t bx;
  tbu_pkg::coord_t by_coord;
  tbu_pkg::coord_t cx;
  tbu_pkg::coord_t cy;
  tbu_pkg::coord_t px;
  tbu_pkg::coord_t py;
  modport source (output valid, ax, ay, bx, by_coord, cx, cy, px, py, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, px, py, output ready);
endinterface

interface tbu_out_if;
  logic          valid;
  logic          ready;
  tbu_pkg::wgt_t alpha;
  tbu_pkg::wgt_t beta;
  tbu_pkg::wgt_t gamma;
  logic          degenerate;
  modport source (output valid, alpha, beta, gamma, degenerate, input ready);
  modport sink   (input valid, alpha, beta, gamma, degenerate, output ready);
endinterface

// File: sv/tbu_div.sv
// One divider lane: pipelined restoring division, one quotient bit a stage,
// with rounding sign fix-up and saturation. Depends on tbu_pkg.
module tbu_div (
  input  logic              clk,
  input  tbu_pkg::div_ctl_t ctl,
  input  tbu_pkg::mag_t     m,
  input  tbu_pkg::dvs_t     d,
  input  logic              neg,
  input  logic              ovf,
  output tbu_pkg::wgt_t     w
);

  tbu_pkg::rem_t rem_r   [tbu_pkg::QB];
  tbu_pkg::rem_t rem_nxt [tbu_pkg::QB];
  tbu_pkg::quo_t q_r     [tbu_pkg::QB];
  tbu_pkg::quo_t q_nxt   [tbu_pkg::QB];
  tbu_pkg::dvs_t d_r     [tbu_pkg::QB];
  logic          neg_r   [tbu_pkg::QB];
  logic          ovf_r   [tbu_pkg::QB];

  tbu_pkg::rem_t rem_in  [tbu_pkg::QB];
  tbu_pkg::quo_t q_in    [tbu_pkg::QB];
  tbu_pkg::dvs_t d_in    [tbu_pkg::QB];
  logic          neg_in  [tbu_pkg::QB];
  logic          ovf_in  [tbu_pkg::QB];

  tbu_pkg::wgt_t u_ext;

  genvar k;
  generate
    for (k = 0; k < tbu_pkg::QB; k++) begin : g_stage
      localparam int BIT = tbu_pkg::QB - 1 - k;
      tbu_pkg::rem_t sh;
      logic          take;

      // Feed from the lane inputs or the previous stage
      if (k == 0) begin : g_first
        assign rem_in[k] = tbu_pkg::rem_t'(m);
        assign q_in[k]   = '0;
        assign d_in[k]   = d;
        assign neg_in[k] = neg;
        assign ovf_in[k] = ovf;
      end else begin : g_next
        assign rem_in[k] = rem_r[k-1];
        assign q_in[k]   = q_r[k-1];
        assign d_in[k]   = d_r[k-1];
        assign neg_in[k] = neg_r[k-1];
        assign ovf_in[k] = ovf_r[k-1];
      end

      // Trial subtract of the shifted divisor
      assign sh   = tbu_pkg::rem_t'(d_in[k]) << BIT;
      assign take = (rem_in[k] >= sh);

      always_comb begin
        rem_nxt[k]    = take ? (rem_in[k] - sh) : rem_in[k];
        q_nxt[k]      = q_in[k];
        q_nxt[k][BIT] = take;
      end

      // Advance the stage when the pipeline moves
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rem_r[k] <= rem_nxt[k];
          q_r[k]   <= q_nxt[k];
          d_r[k]   <= d_in[k];
          neg_r[k] <= neg_in[k];
          ovf_r[k] <= ovf_in[k];
        end
      end
    end
  endgenerate

  // Floor of a negative numerator is the complement of the magnitude quotient
  assign u_ext = {1'b0, q_r[tbu_pkg::QB-1]};

  always_comb begin
    if (ovf_r[tbu_pkg::QB-1]) begin
      w = neg_r[tbu_pkg::QB-1] ? tbu_pkg::WGT_MIN : tbu_pkg::WGT_MAX;
    end else begin
      w = neg_r[tbu_pkg::QB-1] ? ~u_ext : u_ext;
    end
  end

endmodule

// File: sv/triangle_barycentric_unit_top.sv
// Top level of the triangle barycentric unit.
// Depends on tbu_pkg, tbu_if (tbu_in_if, tbu_out_if) and tbu_div.
//
// Takes one triangle and sample point per transaction and returns one
// transaction with the three Q8.16 weights and a degenerate flag. The block
// accepts a transaction every clock unless the output stalls. The pipeline is
// one stage of coordinate differences, one of multipliers, one of edge and
// determinant subtraction, one of numerator set-up and overflow test, 23
// restoring-division stages (one quotient bit each, three lanes in parallel)
// and the output register. A stall on the output side holds the whole
// pipeline; bubbles are filled while the output is free.
module triangle_barycentric_unit_top (
  input  logic      clk,
  input  logic      rst_n,
  tbu_in_if.sink    in_if,
  tbu_out_if.source out_if
);

  localparam int QB = tbu_pkg::QB;

  logic en;
  tbu_pkg::div_ctl_t div_ctl;

  // Stage 1: differences
  tbu_pkg::diff_t d_bax_r, d_cay_r, d_cax_r, d_bay_r;
  tbu_pkg::diff_t d_cbx_r, d_pby_r, d_cby_r, d_pbx_r;
  tbu_pkg::diff_t d_acx_r, d_pcy_r, d_acy_r, d_pcx_r;
  tbu_pkg::diff_t d_pay_r, d_pax_r;
  logic           v1_r;

  // Stage 2: products
  tbu_pkg::prod_t p_d0_r, p_d1_r, p_a0_r, p_a1_r, p_b0_r, p_b1_r, p_g0_r, p_g1_r;
  logic           v2_r;

  // Stage 3: determinant and edge functions
  tbu_pkg::edge_t det_r, e_a_r, e_b_r, e_g_r;
  logic           v3_r;

  // Stage 4: division operands
  tbu_pkg::num_t  n_a, n_b, n_g;
  tbu_pkg::mag_t  m_a_r, m_b_r, m_g_r, m_a_nxt, m_b_nxt, m_g_nxt;
  logic           ng_a_r, ng_b_r, ng_g_r;
  logic           ov_a_r, ov_b_r, ov_g_r;
  tbu_pkg::dvs_t  dv_r, dv_nxt;
  tbu_pkg::rem_t  lim;
  logic           dg4_r;
  logic           v4_r;

  // Division stages: valid and flag travel alongside
  logic           vd_r [QB];
  logic           dgd_r[QB];

  tbu_pkg::wgt_t  w_a, w_b, w_g;

  // Output register
  logic           out_valid_r;
  tbu_pkg::wgt_t  alpha_r, beta_r, gamma_r;
  logic           degen_r;

  // Whole pipeline advances unless a result is held
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;
  assign div_ctl.en  = en;

  always_ff @(posedge clk) begin
    if (en) begin
      d_bax_r <= tbu_pkg::sub_ext(in_if.bx,       in_if.ax);
      d_cay_r <= tbu_pkg::sub_ext(in_if.cy,       in_if.ay);
      d_cax_r <= tbu_pkg::sub_ext(in_if.cx,       in_if.ax);
      d_bay_r <= tbu_pkg::sub_ext(in_if.by_coord, in_if.ay);
      d_cbx_r <= tbu_pkg::sub_ext(in_if.cx,       in_if.bx);
      d_pby_r <= tbu_pkg::sub_ext(in_if.py,       in_if.by_coord);
      d_cby_r <= tbu_pkg::sub_ext(in_if.cy,       in_if.by_coord);
      d_pbx_r <= tbu_pkg::sub_ext(in_if.px,       in_if.bx);
      d_acx_r <= tbu_pkg::sub_ext(in_if.ax,       in_if.cx);
      d_pcy_r <= tbu_pkg::sub_ext(in_if.py,       in_if.cy);
      d_acy_r <= tbu_pkg::sub_ext(in_if.ay,       in_if.cy);
      d_pcx_r <= tbu_pkg::sub_ext(in_if.px,       in_if.cx);
      d_pay_r <= tbu_pkg::sub_ext(in_if.py,       in_if.ay);
      d_pax_r <= tbu_pkg::sub_ext(in_if.px,       in_if.ax);
      p_d0_r  <= tbu_pkg::mul_ext(d_bax_r, d_cay_r);
      p_d1_r  <= tbu_pkg::mul_ext(d_cax_r, d_bay_r);
      p_a0_r  <= tbu_pkg::mul_ext(d_cbx_r, d_pby_r);
      p_a1_r  <= tbu_pkg::mul_ext(d_cby_r, d_pbx_r);
      p_b0_r  <= tbu_pkg::mul_ext(d_acx_r, d_pcy_r);
      p_b1_r  <= tbu_pkg::mul_ext(d_acy_r, d_pcx_r);
      p_g0_r  <= tbu_pkg::mul_ext(d_bax_r, d_pay_r);
      p_g1_r  <= tbu_pkg::mul_ext(d_bay_r, d_pax_r);
      det_r   <= tbu_pkg::edge_t'(p_d0_r) - tbu_pkg::edge_t'(p_d1_r);
      e_a_r   <= tbu_pkg::edge_t'(p_a0_r) - tbu_pkg::edge_t'(p_a1_r);
      e_b_r   <= tbu_pkg::edge_t'(p_b0_r) - tbu_pkg::edge_t'(p_b1_r);
      e_g_r   <= tbu_pkg::edge_t'(p_g0_r) - tbu_pkg::edge_t'(p_g1_r);
      m_a_r   <= m_a_nxt;
      m_b_r   <= m_b_nxt;
      m_g_r   <= m_g_nxt;
      ng_a_r  <= n_a[tbu_pkg::NW-1];
      ng_b_r  <= n_b[tbu_pkg::NW-1];
      ng_g_r  <= n_g[tbu_pkg::NW-1];
      ov_a_r  <= (tbu_pkg::rem_t'(m_a_nxt) >= lim);
      ov_b_r  <= (tbu_pkg::rem_t'(m_b_nxt) >= lim);
      ov_g_r  <= (tbu_pkg::rem_t'(m_g_nxt) >= lim);
      dv_r    <= dv_nxt;
      dg4_r   <= det_r[tbu_pkg::EW-1] || (det_r == '0);
    end
  end

  // Rounded numerator 2*E*2^F + det, folded to a magnitude for floor division
  always_comb begin
    n_a     = (tbu_pkg::num_t'(e_a_r) <<< (tbu_pkg::FRAC_BITS + 1)) +
              tbu_pkg::num_t'(det_r);
    n_b     = (tbu_pkg::num_t'(e_b_r) <<< (tbu_pkg::FRAC_BITS + 1)) +
              tbu_pkg::num_t'(det_r);
    n_g     = (tbu_pkg::num_t'(e_g_r) <<< (tbu_pkg::FRAC_BITS + 1)) +
              tbu_pkg::num_t'(det_r);
    m_a_nxt = n_a[tbu_pkg::NW-1] ? tbu_pkg::mag_t'(~n_a) : tbu_pkg::mag_t'(n_a);
    m_b_nxt = n_b[tbu_pkg::NW-1] ? tbu_pkg::mag_t'(~n_b) : tbu_pkg::mag_t'(n_b);
    m_g_nxt = n_g[tbu_pkg::NW-1] ? tbu_pkg::mag_t'(~n_g) : tbu_pkg::mag_t'(n_g);
    dv_nxt  = tbu_pkg::dvs_t'(det_r) << 1;
    lim     = tbu_pkg::rem_t'(dv_nxt) << QB;
  end

  tbu_div u_div_a (.clk(clk), .ctl(div_ctl), .m(m_a_r), .d(dv_r),
                   .neg(ng_a_r), .ovf(ov_a_r), .w(w_a));
  tbu_div u_div_b (.clk(clk), .ctl(div_ctl), .m(m_b_r), .d(dv_r),
                   .neg(ng_b_r), .ovf(ov_b_r), .w(w_b));
  tbu_div u_div_g (.clk(clk), .ctl(div_ctl), .m(m_g_r), .d(dv_r),
                   .neg(ng_g_r), .ovf(ov_g_r), .w(w_g));

  // Carry the degenerate flag beside the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      dgd_r[0] <= dg4_r;
      for (int i = 1; i < QB; i++) begin
        dgd_r[i] <= dgd_r[i-1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QB; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r        <= in_if.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vd_r[0]     <= v4_r;
      for (int i = 1; i < QB; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      out_valid_r <= vd_r[QB-1];
    end
  end

  // Output register: substitute the fixed weights for a degenerate triangle
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= dgd_r[QB-1] ? tbu_pkg::DEG_ALPHA : w_a;
      beta_r  <= dgd_r[QB-1] ? '0 : w_b;
      gamma_r <= dgd_r[QB-1] ? '0 : w_g;
      degen_r <= dgd_r[QB-1];
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.alpha      = alpha_r;
  assign out_if.beta       = beta_r;
  assign out_if.gamma      = gamma_r;
  assign out_if.degenerate = degen_r;

  // A degenerate result carries zero beta and gamma
  a_degen_weights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && degen_r) |-> (beta_r == '0 && gamma_r == '0))
    else $error("degenerate result with nonzero weights");

  // An accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && en) |=> v1_r)
    else $error("accepted transaction lost at entry");

  // The input is never blocked while no result is held
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input blocked with empty output register");

endmodule

// File: sim/triangle_barycentric_unit_top_test.sv
// Self-checking testbench for the triangle barycentric unit top level.
// Depends on tbu_pkg, tbu_if and the RTL of triangle_barycentric_unit_top.
// Drives triangles with bursty traffic and checks the weights and degenerate flag of every result.
module triangle_barycentric_unit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tbu_pkg::wgt_t alpha;
    tbu_pkg::wgt_t beta;
    tbu_pkg::wgt_t gamma;
    logic          degenerate;
  } weights_t;

  typedef struct {
    tbu_pkg::coord_t ax, ay, bx, by, cx, cy, px, py;
  } tri_t;

  localparam int LATENCY = 28;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  tbu_in_if  in_if ();
  tbu_out_if out_if ();

  triangle_barycentric_unit_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  weights_t expected_weights[$];
  int       n_errors;
  longint   cycle_count;
  bit       hold_off;
  int       stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and end the run on a timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    n_errors++;
  endtask

  // Round to nearest, ties up, then clamp to the output range
  function automatic tbu_pkg::wgt_t scaled_weight(input longint e, input longint det);
    longint n, d, q;
    n = 2 * e * (longint'(1) <<< tbu_pkg::FRAC_BITS) + det;
    d = 2 * det;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    if (q > longint'(tbu_pkg::WGT_MAX)) q = longint'(tbu_pkg::WGT_MAX);
    if (q < longint'(tbu_pkg::WGT_MIN)) q = longint'(tbu_pkg::WGT_MIN);
    return tbu_pkg::wgt_t'(q);
  endfunction

  function automatic longint edge_fn(input longint ux, uy, vx, vy, qx, qy);
    return (vx - ux) * (qy - uy) - (vy - uy) * (qx - ux);
  endfunction

  function automatic weights_t predict_weights(input tri_t t);
    weights_t w;
    longint ax, ay, bx, by, cx, cy, px, py, det, ea;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
    cx = t.cx; cy = t.cy; px = t.px; py = t.py;
    det = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (det <= 0) begin
      ea = -(longint'(1) <<< tbu_pkg::FRAC_BITS);
      if (ea < longint'(tbu_pkg::WGT_MIN)) ea = longint'(tbu_pkg::WGT_MIN);
      w.alpha = tbu_pkg::wgt_t'(ea);
      w.beta = '0;
      w.gamma = '0;
      w.degenerate = 1'b1;
    end else begin
      w.alpha = scaled_weight(edge_fn(bx, by, cx, cy, px, py), det);
      w.beta = scaled_weight(edge_fn(cx, cy, ax, ay, px, py), det);
      w.gamma = scaled_weight(edge_fn(ax, ay, bx, by, px, py), det);
      w.degenerate = 1'b0;
    end
    return w;
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_triangle(input tri_t t);
    in_if.valid    <= 1'b1;
    in_if.ax       <= t.ax;
    in_if.ay       <= t.ay;
    in_if.bx       <= t.bx;
    in_if.by_coord <= t.by;
    in_if.cx       <= t.cx;
    in_if.cy       <= t.cy;
    in_if.px       <= t.px;
    in_if.py       <= t.py;
    expected_weights.push_back(predict_weights(t));
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic idle_input(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    idle_input(1);
    while (expected_weights.size() != 0) @(posedge clk);
  endtask

  function automatic tbu_pkg::coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return tbu_pkg::coord_t'(12'sh800);
      1: return tbu_pkg::coord_t'(12'sh7FF);
      2: return tbu_pkg::coord_t'($urandom_range(0, 15) - 8);
      default: return tbu_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly front-facing triangles with the sample near them; some noise
  function automatic tri_t rnd_triangle();
    tri_t t;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(1, 64);
    t.ax = rnd_coord(); t.ay = rnd_coord();
    t.bx = rnd_coord(); t.by = rnd_coord();
    t.cx = rnd_coord(); t.cy = rnd_coord();
    t.px = rnd_coord(); t.py = rnd_coord();
    if ($urandom_range(0, 3) != 0) begin
      t.ax = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      t.ay = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      t.bx = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      t.by = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      t.cx = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      t.cy = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
      if ((longint'(t.bx) - t.ax) * (longint'(t.cy) - t.ay) -
          (longint'(t.cx) - t.ax) * (longint'(t.by) - t.ay) < 0) begin
        t.bx = t.cx; t.by = t.cy;
        t.cx = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
        t.cy = tbu_pkg::coord_t'($urandom_range(0, 2 * span) - span);
        if ((longint'(t.bx) - t.ax) * (longint'(t.cy) - t.ay) -
            (longint'(t.cx) - t.ax) * (longint'(t.by) - t.ay) < 0) begin
          {t.bx, t.cx} = {t.cx, t.bx};
          {t.by, t.cy} = {t.cy, t.by};
        end
      end
      t.px = tbu_pkg::coord_t'($urandom_range(0, 2 * span + 4) - span - 2);
      t.py = tbu_pkg::coord_t'($urandom_range(0, 2 * span + 4) - span - 2);
    end
    return t;
  endfunction

  function automatic tri_t make_tri(input int ax, ay, bx, by, cx, cy, px, py);
    tri_t t;
    t.ax = tbu_pkg::coord_t'(ax); t.ay = tbu_pkg::coord_t'(ay);
    t.bx = tbu_pkg::coord_t'(bx); t.by = tbu_pkg::coord_t'(by);
    t.cx = tbu_pkg::coord_t'(cx); t.cy = tbu_pkg::coord_t'(cy);
    t.px = tbu_pkg::coord_t'(px); t.py = tbu_pkg::coord_t'(py);
    return t;
  endfunction

  // Random bursts and gaps on the input side
  task automatic send_random(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        send_triangle(rnd_triangle());
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    weights_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_weights.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = expected_weights.pop_front();
        if (out_if.alpha !== w.alpha) report("alpha", out_if.alpha, w.alpha);
        if (out_if.beta !== w.beta) report("beta", out_if.beta, w.beta);
        if (out_if.gamma !== w.gamma) report("gamma", out_if.gamma, w.gamma);
        if (out_if.degenerate !== w.degenerate)
          report("degenerate", out_if.degenerate, w.degenerate);
      end
    end
  end

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 16, 0, 0, 16, 4, 4));
    send_triangle(make_tri(0, 0, 16, 0, 0, 16, 0, 0));          // on vertex A
    send_triangle(make_tri(0, 0, 16, 0, 0, 16, 16, 0));         // on vertex B
    send_triangle(make_tri(0, 0, 3, 0, 0, 3, 1, 1));            // weights of one third
    send_triangle(make_tri(0, 0, 16, 0, 0, 16, 8, 8));          // on edge BC
    send_triangle(make_tri(0, 0, 0, 16, 16, 0, 4, 4));          // back-facing
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 1, 1));            // zero area
    send_triangle(make_tri(0, 0, 10, 10, 20, 20, 3, 3));        // collinear
    send_triangle(make_tri(0, 0, 1, 0, 0, 1, 2047, 2047));      // saturate high
    send_triangle(make_tri(0, 0, 1, 0, 0, 1, -2048, -2048));    // saturate low
    send_triangle(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, 0, 0));
    send_triangle(make_tri(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047));
    send_triangle(make_tri(2047, 2047, -2048, 2047, 2047, -2048, -1, -1));
    send_triangle(make_tri(-2048, 2047, -2048, -2048, 2047, 2047, -2048, -2048));
    send_triangle(make_tri(-1, -1, 0, -1, -1, 0, -1, -1));
    send_triangle(make_tri(1365, 2047, -2048, 0, 2047, -2048, 682, 11));
    send_triangle(make_tri(0, 0, 2047, 1, 0, 2047, 2047, 2047));
    drain_results();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(80);
    join
    drain_results();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      stall_mode = phase;
      send_random(600);
      drain_results();
    end
  endtask

  initial begin
    n_errors = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    stall_mode = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    {in_if.ax, in_if.ay, in_if.bx, in_if.by_coord} = '0;
    {in_if.cx, in_if.cy, in_if.px, in_if.py} = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_mode = 2;
    test_backpressure();
    test_random();
    idle_input(LATENCY + 10);
    if (n_errors == 0 && expected_weights.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
